FILE: rtl/u16u8_pkg.sv
// shared types, constants and the code point encoder for the utf-16 to utf-8 transcoder
// no dependencies; imported by every module of the block
`default_nettype none

package u16u8_pkg;

    // longest byte run one code unit can produce
    localparam int RUN_MAX     = 6;
    localparam int RUN_CNT_W   = 3;
    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // replacement byte and utf-16 surrogate bounds
    localparam logic [7:0]  QMARK      = 8'h3f;
    localparam logic [15:0] HIGH_FIRST = 16'hd800;
    localparam logic [15:0] LOW_FIRST  = 16'hdc00;
    localparam logic [15:0] LOW_END    = 16'he000;
    localparam logic [31:0] PAIR_BASE  = 32'h0001_0000;

    // utf-8 lead and continuation marks
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] LEAD2_MARK = 8'hc0;
    localparam logic [7:0] LEAD3_MARK = 8'he0;
    localparam logic [7:0] LEAD4_MARK = 8'hf0;
    localparam logic [7:0] LEAD5_MARK = 8'hf8;
    localparam logic [7:0] LEAD6_MARK = 8'hfc;

    // one input word
    typedef struct packed {
        logic [31:0] code_unit;
        logic        end_of_string;
    } in_word_t;

    // one output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_word_t;

    // bytes produced for one input word, first byte at index 0
    typedef struct packed {
        logic [RUN_CNT_W-1:0]         count;
        logic [RUN_MAX-1:0][7:0]      bytes;
    } run_t;

    // continuation byte carrying six bits of a code point
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        cont_byte = CONT_MARK | {2'b00, bits};
    endfunction

    // legacy utf-8 encoding, one to six bytes, bit 31 dropped
    function automatic run_t encode_cp(input logic [31:0] cp);
        run_t r;
        r = '0;
        if (cp < 32'h80)
        begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp < 32'h800)
        begin
            r.count    = 3'd2;
            r.bytes[0] = LEAD2_MARK | {3'b000, cp[10:6]};
            r.bytes[1] = cont_byte(cp[5:0]);
        end
        else if (cp < 32'h1_0000)
        begin
            r.count    = 3'd3;
            r.bytes[0] = LEAD3_MARK | {4'b0000, cp[15:12]};
            r.bytes[1] = cont_byte(cp[11:6]);
            r.bytes[2] = cont_byte(cp[5:0]);
        end
        else if (cp < 32'h20_0000)
        begin
            r.count    = 3'd4;
            r.bytes[0] = LEAD4_MARK | {5'b00000, cp[20:18]};
            r.bytes[1] = cont_byte(cp[17:12]);
            r.bytes[2] = cont_byte(cp[11:6]);
            r.bytes[3] = cont_byte(cp[5:0]);
        end
        else if (cp < 32'h400_0000)
        begin
            r.count    = 3'd5;
            r.bytes[0] = LEAD5_MARK | {6'b000000, cp[25:24]};
            r.bytes[1] = cont_byte(cp[23:18]);
            r.bytes[2] = cont_byte(cp[17:12]);
            r.bytes[3] = cont_byte(cp[11:6]);
            r.bytes[4] = cont_byte(cp[5:0]);
        end
        else
        begin
            r.count    = 3'd6;
            r.bytes[0] = LEAD6_MARK | {7'b0000000, cp[30]};
            r.bytes[1] = cont_byte(cp[29:24]);
            r.bytes[2] = cont_byte(cp[23:18]);
            r.bytes[3] = cont_byte(cp[17:12]);
            r.bytes[4] = cont_byte(cp[11:6]);
            r.bytes[5] = cont_byte(cp[5:0]);
        end
        encode_cp = r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/u16u8_front.sv
// front end: takes code units, tracks surrogate state and builds the byte run for each word
// depends on u16u8_pkg
`default_nettype none

module u16u8_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                cfg_data,
    input  wire logic                unit_valid,
    output logic                     unit_ready,
    input  wire u16u8_pkg::in_word_t unit_word,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output u16u8_pkg::run_t          push_run
);
    import u16u8_pkg::*;

    logic       utf32_reg;
    logic [9:0] held_reg, held_next;
    logic       pending_reg, pending_next;
    logic       skip_reg, skip_next;

    logic        accept;
    logic [15:0] w;
    logic        is_low, is_high;
    logic [31:0] pair_cp;
    run_t        enc_unit, enc_w, enc_pair;
    run_t        body;
    logic        pre, suf;
    run_t        run;
    logic [RUN_CNT_W-1:0] pos;

    assign accept     = unit_valid && unit_ready;
    assign unit_ready = push_ready;

    // classification of the incoming unit
    assign w        = unit_word.code_unit[15:0];
    assign is_low   = (w >= LOW_FIRST) && (w < LOW_END);
    assign is_high  = (w >= HIGH_FIRST) && (w < LOW_FIRST);
    assign pair_cp  = 32'({held_reg, w[9:0]}) + PAIR_BASE;
    assign enc_unit = encode_cp(unit_word.code_unit);
    assign enc_w    = encode_cp({16'h0000, w});
    assign enc_pair = encode_cp(pair_cp);

    // body bytes, leading and trailing replacement, next surrogate state
    always_comb
    begin
        body         = '0;
        pre          = 1'b0;
        suf          = 1'b0;
        held_next    = held_reg;
        pending_next = pending_reg;
        skip_next    = skip_reg;
        if (utf32_reg)
        begin
            body         = enc_unit;
            pending_next = 1'b0;
            skip_next    = 1'b0;
            held_next    = '0;
        end
        else if (pending_reg && is_low)
        begin
            body         = enc_pair;
            pending_next = 1'b0;
            skip_next    = 1'b0;
        end
        else
        begin
            pre          = pending_reg;
            pending_next = 1'b0;
            if (is_low)
            begin
                if (!skip_reg)
                begin
                    body.count    = 3'd1;
                    body.bytes[0] = QMARK;
                end
                skip_next = 1'b1;
            end
            else
            begin
                skip_next = 1'b0;
                if (is_high)
                begin
                    held_next    = w[9:0];
                    pending_next = 1'b1;
                    suf          = unit_word.end_of_string;
                end
                else
                begin
                    body = enc_w;
                end
            end
        end
        // end of string flushes all surrogate state
        if (unit_word.end_of_string)
        begin
            held_next    = '0;
            pending_next = 1'b0;
            skip_next    = 1'b0;
        end
    end

    // place leading '?', body and trailing '?' into one run
    always_comb
    begin
        run       = '0;
        pos       = '0;
        run.count = RUN_CNT_W'({2'b00, pre}) + body.count + RUN_CNT_W'({2'b00, suf});
        for (int i = 0; i < RUN_MAX; i++)
        begin
            pos = RUN_CNT_W'(i) - RUN_CNT_W'({2'b00, pre});
            if (pre && (i == 0))
                run.bytes[i] = QMARK;
            else if (pos < body.count)
                run.bytes[i] = body.bytes[pos];
            else
                run.bytes[i] = QMARK;
        end
    end

    assign push_valid = accept && (run.count != '0);
    assign push_run   = run;

    // mode register and surrogate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf32_reg   <= 1'b0;
            held_reg    <= '0;
            pending_reg <= 1'b0;
            skip_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                utf32_reg <= cfg_data;
            if (accept)
            begin
                held_reg    <= held_next;
                pending_reg <= pending_next;
                skip_reg    <= skip_next;
            end
        end
    end

    // a held high surrogate and swallowing of lows never coexist
    a_state_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(pending_reg && skip_reg))
        else $error("high surrogate held while swallowing lows");

    // direct mode leaves no surrogate state behind
    a_utf32_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && utf32_reg) |=> (!pending_reg && !skip_reg))
        else $error("surrogate state survived a direct-mode word");

    // every queued run fits the queue entry
    a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_run.count <= RUN_CNT_W'(RUN_MAX)))
        else $error("byte run longer than six bytes");

endmodule

`default_nettype wire

FILE: rtl/u16u8_fifo.sv
// short queue of byte runs between the front end and the byte serialiser
// depends on u16u8_pkg
`default_nettype none

module u16u8_fifo #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire u16u8_pkg::run_t push_run,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output u16u8_pkg::run_t      pop_run
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    run_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_run    = store_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_run;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // fill count stays within depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    // a lone push raises the fill count by one
    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill count missed a push");

endmodule

`default_nettype wire

FILE: rtl/u16u8_back.sv
// byte serialiser: walks the run at the head of the queue, one byte per cycle while byte_ready holds
// depends on u16u8_pkg
`default_nettype none

module u16u8_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire u16u8_pkg::run_t pop_run,
    output logic                 byte_valid,
    input  wire logic            byte_ready,
    output u16u8_pkg::out_word_t byte_word
);
    import u16u8_pkg::*;

    logic [RUN_CNT_W-1:0] idx_reg;
    logic                 out_valid_reg;
    out_word_t            out_word_reg;
    logic                 load, last;

    // next byte moves into the output register when it is free or being taken
    assign load      = pop_valid && (!out_valid_reg || byte_ready);
    assign last      = (idx_reg == (pop_run.count - RUN_CNT_W'(1)));
    assign pop_ready = load && last;

    assign byte_valid = out_valid_reg;
    assign byte_word  = out_word_reg;

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg.out_byte    <= pop_run.bytes[idx_reg];
            out_word_reg.last_of_run <= last;
        end
    end

    // byte index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= last ? '0 : idx_reg + RUN_CNT_W'(1);
            if (load)
                out_valid_reg <= 1'b1;
            else if (byte_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // the index never runs past the run at the head
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid |-> (idx_reg < pop_run.count))
        else $error("byte index beyond the head run");

endmodule

`default_nettype wire

FILE: rtl/utf16_to_utf8_transcoder_top.sv
// top level of the utf-16 / utf-32 to utf-8 transcoder
// depends on u16u8_pkg, u16u8_front, u16u8_fifo and u16u8_back
`default_nettype none

// Takes one code unit per word on the unit channel and gives utf-8 bytes, one per word, on
// the byte channel, with last_of_run set on the final byte caused by each unit. A unit is
// accepted in every cycle while the run queue (QUEUE_DEPTH entries) has room; units that
// cause no bytes (a held high surrogate, a swallowed low surrogate) never enter the queue.
// The serialiser gives one byte per cycle while byte_ready holds; a unit with several bytes
// holds the byte port until its last byte is taken; plain ASCII runs at one unit per cycle
// without stalls. A unit's first byte passes through the run queue and the serialiser output
// register. cfg_data sets direct (utf-32) mode when 1; write it only while the block is idle.

module utf16_to_utf8_transcoder_top #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                cfg_data,
    input  wire logic                unit_valid,
    output logic                     unit_ready,
    input  wire u16u8_pkg::in_word_t unit_word,
    output logic                     byte_valid,
    input  wire logic                byte_ready,
    output u16u8_pkg::out_word_t     byte_word
);
    import u16u8_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    run_t push_run, pop_run;

    // classification and run building
    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_word  (unit_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run)
    );

    // run queue
    u16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_run   (push_run),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_run    (pop_run)
    );

    // byte serialiser
    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_run    (pop_run),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for utf16_to_utf8_transcoder_top: directed table, then random phases
// depends on u16u8_pkg and the transcoder rtl; holds its own transcoding predictor
`default_nettype none

module testbench;

    import u16u8_pkg::*;

    // run shape
    localparam int CYCLE_LIMIT       = 200000;
    localparam int TAIL_CYCLES       = 10;
    localparam int LONG_STALL_AT     = 120;
    localparam int LONG_STALL_CYCLES = 80;
    localparam int UTF16_ITEMS       = 60;
    localparam int UTF32_ITEMS       = 35;
    localparam int NUM_PHASES        = 5;
    localparam int NUM_ROWS          = 25;

    // one row of stimulus; expected bytes read left to right from the top of the field
    typedef struct packed {
        logic        mode_write;
        logic        mode;
        logic [31:0] unit;
        logic        eos;
        logic        typed;
        logic [2:0]  count;
        logic [47:0] bytes;
    } unit_row_t;

    // directed rows: typed rows carry their bytes, the rest go through the predictor
    localparam unit_row_t DIRECTED [NUM_ROWS] = '{
        // zero unit is a plain 0x00 byte
        '{1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b1, 3'd1, 48'h0000_0000_0000},
        '{1'b0, 1'b0, 32'h0000_007f, 1'b0, 1'b1, 3'd1, 48'h7f00_0000_0000},
        '{1'b0, 1'b0, 32'h0000_0080, 1'b0, 1'b1, 3'd2, 48'hc280_0000_0000},
        '{1'b0, 1'b0, 32'h0000_20ac, 1'b0, 1'b0, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_ffff, 1'b0, 1'b1, 3'd3, 48'hefbf_bf00_0000},
        // lowest and highest surrogate pairs
        '{1'b0, 1'b0, 32'h0000_d800, 1'b0, 1'b1, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_dc00, 1'b0, 1'b1, 3'd4, 48'hf090_8080_0000},
        '{1'b0, 1'b0, 32'h0000_dbff, 1'b0, 1'b1, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_dfff, 1'b0, 1'b1, 3'd4, 48'hf48f_bfbf_0000},
        // high after high, then a plain unit with end of string
        '{1'b0, 1'b0, 32'h0000_d801, 1'b0, 1'b1, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_d902, 1'b0, 1'b1, 3'd1, 48'h3f00_0000_0000},
        '{1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b1, 3'd2, 48'h3f00_0000_0000},
        // lone low, then a swallowed low
        '{1'b0, 1'b0, 32'h0000_dc05, 1'b0, 1'b1, 3'd1, 48'h3f00_0000_0000},
        '{1'b0, 1'b0, 32'h0000_dc06, 1'b0, 1'b1, 3'd0, 48'h0},
        '{1'b0, 1'b0, 32'h0000_0042, 1'b0, 1'b1, 3'd1, 48'h4200_0000_0000},
        // end of string flushes a held high
        '{1'b0, 1'b0, 32'h0000_d800, 1'b1, 1'b1, 3'd1, 48'h3f00_0000_0000},
        // upper half ignored in utf-16 mode
        '{1'b0, 1'b0, 32'hffff_0041, 1'b1, 1'b1, 3'd1, 48'h4100_0000_0000},
        // held high is dropped once direct mode takes a unit
        '{1'b0, 1'b0, 32'h0000_dabc, 1'b0, 1'b1, 3'd0, 48'h0},
        '{1'b1, 1'b1, 32'h0000_0041, 1'b0, 1'b1, 3'd1, 48'h4100_0000_0000},
        // direct mode length boundaries, bit 31 dropped
        '{1'b0, 1'b0, 32'h8000_0000, 1'b0, 1'b1, 3'd6, 48'hfc80_8080_8080},
        '{1'b0, 1'b0, 32'hffff_ffff, 1'b1, 1'b1, 3'd6, 48'hfdbf_bfbf_bfbf},
        '{1'b0, 1'b0, 32'h03ff_ffff, 1'b0, 1'b1, 3'd5, 48'hfbbf_bfbf_bf00},
        '{1'b0, 1'b0, 32'h0020_0000, 1'b0, 1'b1, 3'd5, 48'hf888_8080_8000},
        '{1'b0, 1'b0, 32'h001f_ffff, 1'b0, 1'b1, 3'd4, 48'hf7bf_bfbf_0000},
        // surrogate value encoded directly
        '{1'b0, 1'b0, 32'h0000_d800, 1'b0, 1'b1, 3'd3, 48'heda0_8000_0000}
    };

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      cfg_write  = 1'b0;
    logic      cfg_data   = 1'b0;
    logic      unit_valid = 1'b0;
    logic      unit_ready;
    in_word_t  unit_word  = '0;
    logic      byte_valid;
    logic      byte_ready = 1'b0;
    out_word_t byte_word;

    // predictor state
    bit        direct_mode;
    bit        high_held;
    bit        dropping_lows;
    logic [9:0] held_bits;

    // bytes of the current unit, then the store of bytes still to come
    logic [7:0] run_buf [$];
    out_word_t  pending_bytes [$];

    int errors;
    int cycle_count;
    int bytes_taken;
    int tx_calm;
    int rx_calm;
    int rx_hold;
    bit rx_next;

    utf16_to_utf8_transcoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_word  (unit_word),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word)
    );

    always #6 clk = ~clk;

    // random wait per word, with occasional stretches of back-to-back words
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // utf-8 bytes of one code point, six-byte form above 0x3ffffff
    function automatic void put_point(input logic [31:0] cp);
        int n;
        int k;
        logic [7:0]  mark;
        logic [31:0] top;
        logic [31:0] six;
        n = (cp < 32'h80) ? 1 : (cp < 32'h800) ? 2 : (cp < 32'h1_0000) ? 3 :
            (cp < 32'h20_0000) ? 4 : (cp < 32'h400_0000) ? 5 : 6;
        if (n == 1)
        begin
            run_buf.push_back(cp[7:0]);
        end
        else
        begin
            mark = 8'hff << (8 - n);
            top  = cp >> (6 * (n - 1));
            run_buf.push_back(mark | (top[7:0] & (8'hff >> (n + 1))));
            for (k = n - 2; k >= 0; k--)
            begin
                six = cp >> (6 * k);
                run_buf.push_back(8'h80 | {2'b00, six[5:0]});
            end
        end
    endfunction

    // bytes caused by one accepted unit, updating the surrogate state
    function automatic void transcode_unit(input logic [31:0] cu, input logic eos);
        logic [15:0] w;
        bit is_low;
        bit is_high;
        bit paired;
        run_buf.delete();
        w       = cu[15:0];
        is_low  = (w >= LOW_FIRST) && (w < LOW_END);
        is_high = (w >= HIGH_FIRST) && (w < LOW_FIRST);
        paired  = 1'b0;
        if (direct_mode)
        begin
            high_held     = 1'b0;
            held_bits     = '0;
            dropping_lows = 1'b0;
            put_point(cu);
        end
        else
        begin
            // a held high either pairs up or turns into a replacement
            if (high_held)
            begin
                high_held = 1'b0;
                if (is_low)
                begin
                    put_point({12'b0, held_bits, w[9:0]} + PAIR_BASE);
                    dropping_lows = 1'b0;
                    paired        = 1'b1;
                end
                else
                begin
                    run_buf.push_back(QMARK);
                end
            end
            if (!paired)
            begin
                if (is_low)
                begin
                    if (!dropping_lows)
                    begin
                        run_buf.push_back(QMARK);
                        dropping_lows = 1'b1;
                    end
                end
                else
                begin
                    dropping_lows = 1'b0;
                    if (is_high)
                    begin
                        held_bits = w[9:0];
                        high_held = 1'b1;
                    end
                    else
                    begin
                        put_point({16'b0, w});
                    end
                end
            end
        end
        // end of string flushes and clears
        if (eos)
        begin
            if (high_held)
                run_buf.push_back(QMARK);
            high_held     = 1'b0;
            held_bits     = '0;
            dropping_lows = 1'b0;
        end
    endfunction

    // utf-16 unit: mostly pairs and plain text, some broken sequences
    function automatic logic [31:0] pick_utf16_unit(input bit after_high);
        int r;
        logic [15:0] w;
        logic [15:0] upper;
        r = $urandom_range(0, 99);
        if (after_high && r < 75)
        begin
            w = 16'($urandom_range(16'hdc00, 16'hdfff));
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                w = 16'h0000;
            else if (r < 25)
                w = 16'($urandom_range(16'h0001, 16'h007f));
            else if (r < 40)
                w = 16'($urandom_range(16'h0080, 16'h07ff));
            else if (r < 52)
                w = 16'($urandom_range(16'h0800, 16'hd7ff));
            else if (r < 62)
                w = 16'($urandom_range(16'he000, 16'hffff));
            else if (r < 85)
                w = 16'($urandom_range(16'hd800, 16'hdbff));
            else
                w = 16'($urandom_range(16'hdc00, 16'hdfff));
        end
        upper = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
        return {upper, w};
    endfunction

    // utf-32 unit spread over every encoded length
    function automatic logic [31:0] pick_utf32_unit();
        case ($urandom_range(1, 7))
            1: return $urandom_range(32'h0, 32'h7f);
            2: return $urandom_range(32'h80, 32'h7ff);
            3: return $urandom_range(32'h800, 32'hffff);
            4: return $urandom_range(32'h1_0000, 32'h1f_ffff);
            5: return $urandom_range(32'h20_0000, 32'h3ff_ffff);
            6: return $urandom_range(32'h400_0000, 32'hffff_ffff);
            default: return $urandom;
        endcase
    endfunction

    // offer one word and wait for it to be taken, then log its expected bytes
    task automatic send_unit(input unit_row_t row);
        int gap;
        int k;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            unit_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        unit_valid <= 1'b1;
        unit_word  <= '{code_unit: row.unit, end_of_string: row.eos};
        do
            @(posedge clk);
        while (!unit_ready);
        transcode_unit(row.unit, row.eos);
        if (row.typed)
        begin
            run_buf.delete();
            for (k = 0; k < row.count; k++)
                run_buf.push_back(row.bytes[47 - 8 * k -: 8]);
        end
        foreach (run_buf[j])
            pending_bytes.push_back('{out_byte: run_buf[j],
                                      last_of_run: (j == run_buf.size() - 1)});
    endtask

    // stop offering and let every outstanding byte arrive
    task automatic wait_idle();
        unit_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // mode register write while idle
    task automatic set_mode(input logic m);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write   <= 1'b0;
        direct_mode = m;
    endtask

    // compare one received word with the oldest expected one
    function automatic void check_byte(input out_word_t got);
        out_word_t want;
        if (pending_bytes.size() == 0)
        begin
            $error("byte 0x%02h arrived with nothing expected", got.out_byte);
            errors++;
        end
        else
        begin
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
                errors++;
            end
        end
    endfunction

    // byte sink with random back-pressure and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_ready <= 1'b0;
        end
        else
        begin
            rx_next = byte_ready;
            if (byte_valid && byte_ready)
            begin
                check_byte(byte_word);
                bytes_taken++;
                rx_hold = (bytes_taken == LONG_STALL_AT) ? LONG_STALL_CYCLES : draw_gap(rx_calm);
                rx_next = (rx_hold == 0);
            end
            else if (!byte_ready)
            begin
                if (rx_hold > 0)
                    rx_hold--;
                rx_next = (rx_hold == 0);
            end
            byte_ready <= rx_next;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        unit_row_t row;
        logic [31:0] cu;
        bit eos;
        bit prev_high;
        int p;
        int i;
        int items;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].mode_write)
                set_mode(DIRECTED[r].mode);
            send_unit(DIRECTED[r]);
        end

        // random phases, alternating utf-16 and direct mode
        for (p = 0; p < NUM_PHASES; p++)
        begin
            set_mode(1'(p % 2));
            items     = (p % 2) ? UTF32_ITEMS : UTF16_ITEMS;
            prev_high = 1'b0;
            for (i = 0; i < items; i++)
            begin
                // sender pause until the block has drained
                if (p == 2 && i == items / 2)
                    wait_idle();
                cu  = (p % 2) ? pick_utf32_unit() : pick_utf16_unit(prev_high);
                eos = ($urandom_range(0, 11) == 0);
                prev_high = (cu[15:10] == 6'b110110) && !eos;
                row = '{1'b0, 1'b0, cu, eos, 1'b0, 3'd0, 48'h0};
                send_unit(row);
            end
        end

        wait_idle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_fifo.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_transcoder_top.sv
tb/sv/testbench.sv
